@@ rtl/lpsc_pkg.sv @@
// shared types and constants for the length-prefix to start-code converter
// no dependencies
package lpsc_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = 3;
    localparam int CNT_W      = 4;
    localparam int MAX_PUSH   = 3;
    localparam int PUSH_W     = 2;

    localparam logic [7:0] SYNC_PATTERN [MAX_PUSH] = '{8'h00, 8'h00, 8'h01};
    localparam logic [4:0] NAL_TYPE_IDR = 5'd5;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       packet_error;
        logic       idr_found;
    } t_result;

endpackage

@@ rtl/lpsc_out_fifo.sv @@
// result queue: takes up to three result transactions per cycle, hands out one
// depends on lpsc_pkg
module lpsc_out_fifo (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [lpsc_pkg::PUSH_W-1:0]            i_push_n,
    input  lpsc_pkg::t_result                      i_push_data [lpsc_pkg::MAX_PUSH],
    input  logic                                   i_pop,
    output lpsc_pkg::t_result                      o_head,
    output logic                                   o_not_empty,
    output logic                                   o_room
);
    import lpsc_pkg::*;

    t_result            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               pop_ok;

    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];
    assign pop_ok      = i_pop && o_not_empty;

    // room for a full burst, counting the transaction leaving this cycle
    assign o_room = ({1'b0, r_count} + (CNT_W+1)'(MAX_PUSH))
                    <= ((CNT_W+1)'(FIFO_DEPTH) + (CNT_W+1)'(pop_ok));

    assign n_count = r_count + CNT_W'(i_push_n) - CNT_W'(pop_ok);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (PUSH_W'(k) < i_push_n) begin
                r_mem[r_wr_ptr + PTR_W'(k)] <= i_push_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push_n;
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop_ok);
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != '0) |-> ({1'b0, r_count} + (CNT_W+1)'(i_push_n)
            <= (CNT_W+1)'(FIFO_DEPTH) + (CNT_W+1)'(pop_ok)))
        else $error("push without room");

endmodule

@@ rtl/length_prefix_to_start_code.sv @@
// top level: length-prefixed unit stream to start-code stream converter
// depends on lpsc_pkg and lpsc_out_fifo
//
// One byte transaction is taken per cycle. Length bytes produce no output; the
// byte that completes a length produces the three start code bytes 00 00 01,
// and each payload byte produces itself. Results drain through an eight-entry
// queue at one per cycle while i_ready is high; input is held off only while
// that queue lacks room for a three-byte burst, so sustained rate is one byte
// per cycle whenever lengths of LENGTH_BYTES >= 3 separate start codes.
// The final result of a packet carries out_last, the truncation error flag and
// the IDR flag; a packet that ends mid-length yields one error-only result.
module length_prefix_to_start_code #(
    parameter int LENGTH_BYTES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_packet_error,
    output logic       o_idr_found
);
    import lpsc_pkg::*;

    localparam int LEN_W = 8 * LENGTH_BYTES;
    localparam int IDX_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

    logic             r_in_payload, n_in_payload;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [LEN_W-1:0] r_accum, n_accum;
    logic [LEN_W-1:0] r_left, n_left;
    logic             r_at_start, n_at_start;
    logic             r_idr, n_idr;

    logic             accept;
    logic             room;
    logic [LEN_W-1:0] len_next;
    logic             idr_now;
    logic [PUSH_W-1:0] push_n;
    t_result          push_data [MAX_PUSH];
    t_result          head;

    assign accept   = i_valid && o_ready;
    assign o_ready  = room;
    assign len_next = (r_accum << 8) | LEN_W'(i_in_byte);
    assign idr_now  = r_idr || (r_at_start && (i_in_byte[4:0] == NAL_TYPE_IDR));

    always_comb begin
        n_in_payload = r_in_payload;
        n_idx        = r_idx;
        n_accum      = r_accum;
        n_left       = r_left;
        n_at_start   = r_at_start;
        n_idr        = r_idr;
        push_n       = '0;
        for (int k = 0; k < MAX_PUSH; k++) begin
            push_data[k] = '{out_byte: SYNC_PATTERN[k], out_last: 1'b0,
                             packet_error: 1'b0, idr_found: 1'b0};
        end

        if (accept) begin
            if (!r_in_payload) begin
                if (r_idx == IDX_W'(LENGTH_BYTES - 1)) begin
                    n_left  = len_next;
                    n_accum = '0;
                    n_idx   = '0;
                    if (len_next != '0) begin
                        n_in_payload = 1'b1;
                        n_at_start   = 1'b1;
                    end
                    push_n = PUSH_W'(MAX_PUSH);
                    if (i_in_last) begin
                        push_data[MAX_PUSH-1].out_last     = 1'b1;
                        push_data[MAX_PUSH-1].packet_error = (len_next != '0);
                        push_data[MAX_PUSH-1].idr_found    = r_idr;
                    end
                end else begin
                    n_accum = len_next;
                    n_idx   = r_idx + IDX_W'(1);
                    if (i_in_last) begin
                        // packet cut inside a length: error-only transaction
                        push_n       = PUSH_W'(1);
                        push_data[0] = '{out_byte: 8'h00, out_last: 1'b1,
                                         packet_error: 1'b1, idr_found: r_idr};
                    end
                end
            end else begin
                n_idr      = idr_now;
                n_at_start = 1'b0;
                n_left     = r_left - LEN_W'(1);
                if (r_left == LEN_W'(1)) begin
                    n_in_payload = 1'b0;
                end
                push_n       = PUSH_W'(1);
                push_data[0] = '{out_byte: i_in_byte, out_last: i_in_last,
                                 packet_error: i_in_last && (r_left != LEN_W'(1)),
                                 idr_found: i_in_last && idr_now};
            end

            if (i_in_last) begin
                n_in_payload = 1'b0;
                n_idx        = '0;
                n_accum      = '0;
                n_left       = '0;
                n_at_start   = 1'b0;
                n_idr        = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_idx        <= '0;
            r_accum      <= '0;
            r_left       <= '0;
            r_at_start   <= 1'b0;
            r_idr        <= 1'b0;
        end else begin
            r_in_payload <= n_in_payload;
            r_idx        <= n_idx;
            r_accum      <= n_accum;
            r_left       <= n_left;
            r_at_start   <= n_at_start;
            r_idr        <= n_idr;
        end
    end

    lpsc_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_n    (push_n),
        .i_push_data (push_data),
        .i_pop       (i_ready),
        .o_head      (head),
        .o_not_empty (o_valid),
        .o_room      (room)
    );

    assign o_out_byte     = head.out_byte;
    assign o_out_last     = head.out_last;
    assign o_packet_error = head.packet_error;
    assign o_idr_found    = head.idr_found;

    a_payload_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_left != '0))
        else $error("payload mode with nothing owed");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(LENGTH_BYTES - 1))
        else $error("length byte index out of range");

    a_packet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_last) |=> (!r_in_payload && r_idx == '0 && !r_idr
                                   && r_accum == '0))
        else $error("state not cleared at packet end");

    a_start_only_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_at_start |-> r_in_payload)
        else $error("unit start flag outside payload");

endmodule
